// ===== sv/mpr_pkg.sv =====
// shared types and constants for the message packet reassembler
package mpr_pkg;

	localparam int ID_W   = 17;
	localparam int IDX_W  = 4;
	localparam int TOT_W  = 5;
	localparam int DATA_W = 64;

	// hardest limit on packets per message set by the index field
	localparam int IDX_LIMIT = 16;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADIDX = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_ERR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   msg_id;
		logic [IDX_W-1:0]  pkt_index;
		logic [TOT_W-1:0]  pkt_total;
		logic [DATA_W-1:0] payload;
	} pkt_t;

	typedef struct packed {
		logic [ID_W-1:0]   out_msg_id;
		logic [IDX_W-1:0]  out_index;
		logic [DATA_W-1:0] out_payload;
		logic              last;
		status_t           status;
	} res_t;

	// per-entry bookkeeping kept in the entry table memory
	typedef struct packed {
		logic [TOT_W-1:0] total;
		logic [TOT_W-1:0] count;
	} meta_t;

endpackage

// ===== sv/mpr_ram.sv =====
// generic single-write, single-read RAM with registered read data
module mpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/message_packet_reassembler.sv =====
// top level: packet reassembly with entry table and payload memories
//
// Packets are taken one at a time. In the transfer cycle of a packet its id
// is compared against the open-entry ids held in flops and the entry table
// memory is read; in the next cycle the entry is updated and the payload word
// is written to the payload memory. A rejected packet (table full or bad
// index) loads its one result into the output register in that update cycle,
// or later once the output register is free. A packet that completes a
// message of n packets then streams the n stored words out of the payload
// memory, one per cycle while the result side does not stall, each word read
// ahead of its output. The next packet is taken while the last result still
// waits in the output register. No clearing pass is needed after reset: only
// the entry valid bits and the control registers are reset.
module message_packet_reassembler #(
	parameter int MAX_OPEN_MSGS    = 8,
	parameter int MAX_PKTS_PER_MSG = 16,
	parameter int PAYLOAD_BITS     = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pkt_valid,
	output logic           pkt_ready,
	input  mpr_pkg::pkt_t  pkt,
	output logic           res_valid,
	input  logic           res_ready,
	output mpr_pkg::res_t  res
);

	localparam int EW     = (MAX_OPEN_MSGS > 1) ? $clog2(MAX_OPEN_MSGS) : 1;
	localparam int PDEPTH = MAX_OPEN_MSGS * MAX_PKTS_PER_MSG;
	localparam int AW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
	localparam int LIM    = (MAX_PKTS_PER_MSG < mpr_pkg::IDX_LIMIT) ?
	                        MAX_PKTS_PER_MSG : mpr_pkg::IDX_LIMIT;
	localparam logic [mpr_pkg::TOT_W-1:0] PKT_LIM = mpr_pkg::TOT_W'(LIM);
	localparam int MW     = $bits(mpr_pkg::meta_t);

	mpr_pkg::state_t state_q, state_d;

	// open-entry flags and ids, compared in parallel
	logic [MAX_OPEN_MSGS-1:0] valid_q;
	logic [mpr_pkg::ID_W-1:0] id_q [MAX_OPEN_MSGS];

	// packet held for the update cycle
	mpr_pkg::pkt_t   pkt_s1;
	logic            hit_s1;
	logic            free_any_s1;
	logic [EW-1:0]   ent_s1;
	mpr_pkg::status_t err_st_q;

	// emission counters
	logic [mpr_pkg::TOT_W-1:0] n_q;
	logic [mpr_pkg::TOT_W-1:0] k_rd_q;
	logic [mpr_pkg::TOT_W-1:0] k_out_q;
	logic                      rd_pend_q;

	// output register
	logic          res_valid_q;
	mpr_pkg::res_t res_q;

	// lookup signals
	logic                 accept;
	logic                 hit_any, free_any;
	logic [EW-1:0]        hit_ent, free_ent, look_ent;

	// update signals
	mpr_pkg::meta_t            meta_rd, meta_wr;
	logic [MW-1:0]             meta_rdata;
	logic [mpr_pkg::TOT_W-1:0] tot, cnt_old, cnt_new;
	logic [mpr_pkg::TOT_W-1:0] idx_ext;
	logic                      bad, full, err, done, do_upd;

	// payload memory signals
	logic [AW-1:0]           pay_waddr, pay_raddr;
	logic [PAYLOAD_BITS-1:0] pay_rdata;

	// emission and output control
	logic slot_free, load_emit, load_err, issue, last_emit;
	mpr_pkg::status_t err_st;

	assign accept    = pkt_valid && pkt_ready;
	assign slot_free = !res_valid_q || res_ready;

	// id match and lowest free entry, lowest entry wins
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_ent  = '0;
		free_ent = '0;
		for (int i = MAX_OPEN_MSGS - 1; i >= 0; i--) begin
			if (valid_q[i] && id_q[i] == pkt.msg_id) begin
				hit_any = 1'b1;
				hit_ent = EW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_ent = EW'(i);
			end
		end
		look_ent = hit_any ? hit_ent : free_ent;
	end

	// entry table: total and count per entry
	mpr_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_OPEN_MSGS)
	) u_meta_ram (
		.clk  (clk),
		.we   (do_upd),
		.waddr(ent_s1),
		.wdata(meta_wr),
		.re   (accept),
		.raddr(look_ent),
		.rdata(meta_rdata)
	);

	// update decision for the held packet
	always_comb begin
		meta_rd = mpr_pkg::meta_t'(meta_rdata);
		idx_ext = {1'b0, pkt_s1.pkt_index};
		tot     = hit_s1 ? meta_rd.total : pkt_s1.pkt_total;
		cnt_old = hit_s1 ? meta_rd.count : '0;
		cnt_new = cnt_old + 1'b1;
		if (hit_s1) begin
			bad = (idx_ext >= tot) || (idx_ext >= PKT_LIM);
		end else begin
			bad = (tot == '0) || (tot > PKT_LIM) || (idx_ext >= tot);
		end
		full    = !hit_s1 && !free_any_s1 && !bad;
		err     = bad || full;
		done    = (cnt_new == tot);
		do_upd  = (state_q == mpr_pkg::ST_UPD) && !err;
		meta_wr = '{total: tot, count: cnt_new};
		err_st  = bad ? mpr_pkg::STAT_BADIDX : mpr_pkg::STAT_FULL;
	end

	assign pay_waddr = AW'(int'(ent_s1) * MAX_PKTS_PER_MSG + int'(pkt_s1.pkt_index));
	assign pay_raddr = AW'(int'(ent_s1) * MAX_PKTS_PER_MSG + int'(k_rd_q));

	// payload words, one row of slots per entry
	mpr_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(PDEPTH)
	) u_pay_ram (
		.clk  (clk),
		.we   (do_upd),
		.waddr(pay_waddr),
		.wdata(pkt_s1.payload[PAYLOAD_BITS-1:0]),
		.re   (issue),
		.raddr(pay_raddr),
		.rdata(pay_rdata)
	);

	// emission: read ahead one word, load output when the slot frees
	always_comb begin
		load_emit = (state_q == mpr_pkg::ST_EMIT) && rd_pend_q && slot_free;
		issue     = (state_q == mpr_pkg::ST_EMIT) && (k_rd_q < n_q) &&
		            (!rd_pend_q || load_emit);
		last_emit = load_emit && (k_out_q == n_q - 1'b1);
		load_err  = ((state_q == mpr_pkg::ST_UPD) && err && slot_free) ||
		            ((state_q == mpr_pkg::ST_ERR) && slot_free);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpr_pkg::ST_IDLE: begin
				if (pkt_valid) begin
					state_d = mpr_pkg::ST_UPD;
				end
			end
			mpr_pkg::ST_UPD: begin
				if (err) begin
					state_d = slot_free ? mpr_pkg::ST_IDLE : mpr_pkg::ST_ERR;
				end else if (done) begin
					state_d = mpr_pkg::ST_EMIT;
				end else begin
					state_d = mpr_pkg::ST_IDLE;
				end
			end
			mpr_pkg::ST_ERR: begin
				if (slot_free) begin
					state_d = mpr_pkg::ST_IDLE;
				end
			end
			mpr_pkg::ST_EMIT: begin
				if (last_emit) begin
					state_d = mpr_pkg::ST_IDLE;
				end
			end
			default: state_d = mpr_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		pkt_ready = (state_q == mpr_pkg::ST_IDLE);
		res_valid = res_valid_q;
		res       = res_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpr_pkg::ST_IDLE;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
			k_rd_q      <= '0;
			k_out_q     <= '0;
		end else begin
			state_q <= state_d;
			if (do_upd) begin
				valid_q[ent_s1] <= !done;
			end
			if (load_emit || load_err) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == mpr_pkg::ST_UPD) begin
				rd_pend_q <= 1'b0;
				k_rd_q    <= '0;
				k_out_q   <= '0;
			end else begin
				if (issue) begin
					rd_pend_q <= 1'b1;
					k_rd_q    <= k_rd_q + 1'b1;
				end else if (load_emit) begin
					rd_pend_q <= 1'b0;
				end
				if (load_emit) begin
					k_out_q <= k_out_q + 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_s1      <= pkt;
			hit_s1      <= hit_any;
			free_any_s1 <= free_any;
			ent_s1      <= look_ent;
		end
		if (state_q == mpr_pkg::ST_UPD) begin
			n_q      <= tot;
			err_st_q <= err_st;
		end
		if (do_upd && !hit_s1) begin
			id_q[ent_s1] <= pkt_s1.msg_id;
		end
		if (load_err) begin
			res_q.out_msg_id  <= pkt_s1.msg_id;
			res_q.out_index   <= pkt_s1.pkt_index;
			res_q.out_payload <= '0;
			res_q.last        <= 1'b1;
			res_q.status      <= (state_q == mpr_pkg::ST_UPD) ? err_st : err_st_q;
		end else if (load_emit) begin
			res_q.out_msg_id  <= pkt_s1.msg_id;
			res_q.out_index   <= k_out_q[mpr_pkg::IDX_W-1:0];
			res_q.out_payload <= mpr_pkg::DATA_W'(pay_rdata);
			res_q.last        <= (k_out_q == n_q - 1'b1);
			res_q.status      <= mpr_pkg::STAT_OK;
		end
	end

endmodule
